### hw/rtl/fsbc_pkg.sv
// Shared types and constants for the fan speed and boost controller.
`timescale 1ns / 1ps

package fsbc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DEB_W     = 16;
    localparam int unsigned SPEED_W   = 2;
    localparam int unsigned PROFILE_W = 2;
    localparam int unsigned VALUE_W   = 8;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned MIN_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [SPEED_W-1:0]   TOP_SPEED   = 2'd3;
    localparam logic [PROFILE_W-1:0] TOP_PROFILE = 2'd2;
    localparam logic [SPEED_W-1:0]   SPEED_RST   = 2'd2;
    localparam logic [PROFILE_W-1:0] PROFILE_RST = 2'd0;

    localparam logic [TIME_W-1:0] MS_PER_MIN = 32'd60000;
    localparam logic [MIN_W-1:0]  MINUTES_CAP = 7'd99;

    // Remaining time at or above this gives more than 99 minutes when rounded up
    localparam logic [TIME_W-1:0] SAT_REM = 32'd5940001;

    // Below SAT_REM the rounded-up sum fits in REM_W bits
    localparam int unsigned REM_W = 23;
    localparam logic [REM_W-1:0] ROUND_UP_MS = 23'd59999;

    // floor(x / 60000) == (x * RECIP) >> RECIP_SHIFT for every x below 2**23
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 39;
    localparam logic [RECIP_W-1:0] RECIP = 24'd9162597;
    localparam int unsigned PROD_W = REM_W + RECIP_W;

    localparam logic [TIME_W-1:0] BOOST_LEN_RST = 32'd1200000;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 16'd500;
    localparam logic [TIME_W-1:0] LINK_TO_RST   = 32'd10000;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK        = 3'd0,
        KIND_UP          = 3'd1,
        KIND_DOWN        = 3'd2,
        KIND_BOOST       = 3'd3,
        KIND_SET_PROFILE = 3'd4,
        KIND_SPEED_FB    = 3'd5,
        KIND_PROFILE_FB  = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REMOTE_MODE  = 2'd0,
        CFG_BOOST_LENGTH = 2'd1,
        CFG_DEBOUNCE     = 2'd2,
        CFG_LINK_TIMEOUT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              remote_mode;
        logic [TIME_W-1:0] boost_length_ms;
        logic [DEB_W-1:0]  debounce_ms;
        logic [TIME_W-1:0] link_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0]   fan_speed;
        logic                 boost_on;
        logic                 timer_refresh;
        logic [PROFILE_W-1:0] profile;
        logic                 send_speed_valid;
        logic [SPEED_W-1:0]   send_speed_level;
        logic                 send_profile_valid;
        logic [PROFILE_W-1:0] send_profile_code;
        logic                 link_lost;
    } status_t;

endpackage

### hw/rtl/fsbc_cfg.sv
// Configuration register bank.
`timescale 1ns / 1ps

module fsbc_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [fsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsbc_pkg::TIME_W-1:0]     cfg_data,
    output fsbc_pkg::cfg_t                  cfg
);

    fsbc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remote_mode     <= 1'b0;
            cfg_reg.boost_length_ms <= fsbc_pkg::BOOST_LEN_RST;
            cfg_reg.debounce_ms     <= fsbc_pkg::DEBOUNCE_RST;
            cfg_reg.link_timeout_ms <= fsbc_pkg::LINK_TO_RST;
        end
        else if (cfg_valid)
        begin
            case (fsbc_pkg::cfg_index_t'(cfg_index))
                fsbc_pkg::CFG_REMOTE_MODE:  cfg_reg.remote_mode     <= cfg_data[0];
                fsbc_pkg::CFG_BOOST_LENGTH: cfg_reg.boost_length_ms <= cfg_data;
                fsbc_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_ms <= cfg_data[fsbc_pkg::DEB_W-1:0];
                fsbc_pkg::CFG_LINK_TIMEOUT: cfg_reg.link_timeout_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/fsbc_step.sv
// Controller state and the per-event update logic.
`timescale 1ns / 1ps

module fsbc_step
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic [fsbc_pkg::KIND_W-1:0]      kind,
    input  logic [fsbc_pkg::VALUE_W-1:0]     value,
    input  logic [fsbc_pkg::TIME_W-1:0]      now_ms,
    input  fsbc_pkg::cfg_t                   cfg,
    output fsbc_pkg::status_t                status,
    output logic [fsbc_pkg::TIME_W-1:0]      boost_end
);

    logic [fsbc_pkg::SPEED_W-1:0]   speed_now_reg, speed_now_next;
    logic [fsbc_pkg::SPEED_W-1:0]   speed_saved_reg, speed_saved_next;
    logic [fsbc_pkg::PROFILE_W-1:0] profile_now_reg, profile_now_next;
    logic                           boosting_reg, boosting_next;
    logic [fsbc_pkg::TIME_W-1:0]    boost_end_reg, boost_end_next;
    logic [fsbc_pkg::TIME_W-1:0]    last_refresh_reg, last_refresh_next;
    logic                           fb_seen_reg, fb_seen_next;
    logic [fsbc_pkg::TIME_W-1:0]    last_fb_reg, last_fb_next;
    logic                           spd_wait_reg, spd_wait_next;
    logic [fsbc_pkg::SPEED_W-1:0]   spd_wait_level_reg, spd_wait_level_next;
    logic [fsbc_pkg::TIME_W-1:0]    spd_wait_since_reg, spd_wait_since_next;
    logic                           prf_wait_reg, prf_wait_next;
    logic [fsbc_pkg::PROFILE_W-1:0] prf_wait_code_reg, prf_wait_code_next;
    logic [fsbc_pkg::TIME_W-1:0]    prf_wait_since_reg, prf_wait_since_next;

    logic [fsbc_pkg::SPEED_W-1:0]   fb_speed;
    logic [fsbc_pkg::PROFILE_W-1:0] req_profile;
    logic                           boost_expired;
    logic                           minute_passed;
    logic                           spd_due;
    logic                           prf_due;
    logic                           link_stale;
    logic                           is_feedback;

    // Saturate speed feedback, fold unknown profiles to normal
    assign fb_speed    = (value > 8'(fsbc_pkg::TOP_SPEED)) ? fsbc_pkg::TOP_SPEED
                                                             : value[fsbc_pkg::SPEED_W-1:0];
    assign req_profile = (value > 8'(fsbc_pkg::TOP_PROFILE)) ? fsbc_pkg::PROFILE_RST
                                                               : value[fsbc_pkg::PROFILE_W-1:0];

    assign boost_expired = now_ms >= boost_end_reg;
    assign minute_passed = (now_ms - last_refresh_reg) >= fsbc_pkg::MS_PER_MIN;
    assign spd_due = spd_wait_reg
        && ((now_ms - spd_wait_since_reg) >= {16'd0, cfg.debounce_ms});
    assign prf_due = prf_wait_reg
        && ((now_ms - prf_wait_since_reg) >= {16'd0, cfg.debounce_ms});
    assign link_stale  = (now_ms - last_fb_reg) > cfg.link_timeout_ms;
    assign is_feedback = (kind == fsbc_pkg::KIND_SPEED_FB)
                      || (kind == fsbc_pkg::KIND_PROFILE_FB);

    always_comb
    begin
        speed_now_next      = speed_now_reg;
        speed_saved_next    = speed_saved_reg;
        profile_now_next    = profile_now_reg;
        boosting_next       = boosting_reg;
        boost_end_next      = boost_end_reg;
        last_refresh_next   = last_refresh_reg;
        fb_seen_next        = fb_seen_reg;
        last_fb_next        = last_fb_reg;
        spd_wait_next       = spd_wait_reg;
        spd_wait_level_next = spd_wait_level_reg;
        spd_wait_since_next = spd_wait_since_reg;
        prf_wait_next       = prf_wait_reg;
        prf_wait_code_next  = prf_wait_code_reg;
        prf_wait_since_next = prf_wait_since_reg;

        status.timer_refresh      = 1'b0;
        status.send_speed_valid   = 1'b0;
        status.send_speed_level   = '0;
        status.send_profile_valid = 1'b0;
        status.send_profile_code  = '0;

        case (fsbc_pkg::kind_t'(kind))
            fsbc_pkg::KIND_TICK:
            begin
                if (boosting_reg)
                begin
                    if (boost_expired)
                    begin
                        boosting_next           = 1'b0;
                        boost_end_next          = '0;
                        speed_now_next          = speed_saved_reg;
                        status.send_speed_valid = 1'b1;
                        status.send_speed_level = speed_saved_reg;
                    end
                    else if (minute_passed)
                    begin
                        last_refresh_next    = now_ms;
                        status.timer_refresh = 1'b1;
                    end
                end
                // A due debounced command wins over the boost-end command
                if (cfg.remote_mode)
                begin
                    if (spd_due)
                    begin
                        status.send_speed_valid = 1'b1;
                        status.send_speed_level = spd_wait_level_reg;
                        spd_wait_next           = 1'b0;
                    end
                    if (prf_due)
                    begin
                        status.send_profile_valid = 1'b1;
                        status.send_profile_code  = prf_wait_code_reg;
                        prf_wait_next             = 1'b0;
                    end
                end
            end
            fsbc_pkg::KIND_UP, fsbc_pkg::KIND_DOWN:
            begin
                if (boosting_reg)
                begin
                    boosting_next           = 1'b0;
                    boost_end_next          = '0;
                    speed_now_next          = speed_saved_reg;
                    status.send_speed_valid = 1'b1;
                    status.send_speed_level = speed_saved_reg;
                end
                else if ((kind == fsbc_pkg::KIND_UP && speed_now_reg != fsbc_pkg::TOP_SPEED)
                      || (kind == fsbc_pkg::KIND_DOWN && speed_now_reg != '0))
                begin
                    speed_now_next = (kind == fsbc_pkg::KIND_UP) ? speed_now_reg + 2'd1
                                                                   : speed_now_reg - 2'd1;
                    speed_saved_next = speed_now_next;
                    if (cfg.remote_mode)
                    begin
                        spd_wait_next       = 1'b1;
                        spd_wait_level_next = speed_now_next;
                        spd_wait_since_next = now_ms;
                    end
                    else
                    begin
                        status.send_speed_valid = 1'b1;
                        status.send_speed_level = speed_now_next;
                    end
                end
            end
            fsbc_pkg::KIND_BOOST:
            begin
                if (boosting_reg)
                begin
                    boost_end_next = boost_end_reg + cfg.boost_length_ms;
                end
                else
                begin
                    speed_saved_next        = speed_now_reg;
                    speed_now_next          = fsbc_pkg::TOP_SPEED;
                    boosting_next           = 1'b1;
                    boost_end_next          = now_ms + cfg.boost_length_ms;
                    last_refresh_next       = now_ms;
                    status.send_speed_valid = 1'b1;
                    status.send_speed_level = fsbc_pkg::TOP_SPEED;
                end
            end
            fsbc_pkg::KIND_SET_PROFILE:
            begin
                if (boosting_reg)
                begin
                    boosting_next           = 1'b0;
                    boost_end_next          = '0;
                    speed_now_next          = speed_saved_reg;
                    status.send_speed_valid = 1'b1;
                    status.send_speed_level = speed_saved_reg;
                end
                profile_now_next = req_profile;
                if (cfg.remote_mode)
                begin
                    prf_wait_next       = 1'b1;
                    prf_wait_code_next  = req_profile;
                    prf_wait_since_next = now_ms;
                end
                else
                begin
                    status.send_profile_valid = 1'b1;
                    status.send_profile_code  = req_profile;
                end
            end
            fsbc_pkg::KIND_SPEED_FB:
            begin
                fb_seen_next = 1'b1;
                last_fb_next = now_ms;
                if (!boosting_reg && fb_speed != speed_now_reg)
                begin
                    speed_now_next   = fb_speed;
                    speed_saved_next = fb_speed;
                    if (cfg.remote_mode && spd_wait_reg && fb_speed == spd_wait_level_reg)
                    begin
                        spd_wait_next = 1'b0;
                    end
                end
            end
            fsbc_pkg::KIND_PROFILE_FB:
            begin
                fb_seen_next = 1'b1;
                last_fb_next = now_ms;
                if (req_profile != profile_now_reg)
                begin
                    profile_now_next = req_profile;
                    if (cfg.remote_mode && prf_wait_reg && req_profile == prf_wait_code_reg)
                    begin
                        prf_wait_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        status.fan_speed = speed_now_next;
        status.boost_on  = boosting_next;
        status.profile   = profile_now_next;
        // Feedback in this transaction leaves zero silence, so the link is up
        status.link_lost = !fb_seen_next || (!is_feedback && link_stale);
    end

    assign boost_end = boost_end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_now_reg      <= fsbc_pkg::SPEED_RST;
            speed_saved_reg    <= fsbc_pkg::SPEED_RST;
            profile_now_reg    <= fsbc_pkg::PROFILE_RST;
            boosting_reg       <= 1'b0;
            boost_end_reg      <= '0;
            last_refresh_reg   <= '0;
            fb_seen_reg        <= 1'b0;
            last_fb_reg        <= '0;
            spd_wait_reg       <= 1'b0;
            spd_wait_level_reg <= fsbc_pkg::SPEED_RST;
            spd_wait_since_reg <= '0;
            prf_wait_reg       <= 1'b0;
            prf_wait_code_reg  <= fsbc_pkg::PROFILE_RST;
            prf_wait_since_reg <= '0;
        end
        else if (fire)
        begin
            speed_now_reg      <= speed_now_next;
            speed_saved_reg    <= speed_saved_next;
            profile_now_reg    <= profile_now_next;
            boosting_reg       <= boosting_next;
            boost_end_reg      <= boost_end_next;
            last_refresh_reg   <= last_refresh_next;
            fb_seen_reg        <= fb_seen_next;
            last_fb_reg        <= last_fb_next;
            spd_wait_reg       <= spd_wait_next;
            spd_wait_level_reg <= spd_wait_level_next;
            spd_wait_since_reg <= spd_wait_since_next;
            prf_wait_reg       <= prf_wait_next;
            prf_wait_code_reg  <= prf_wait_code_next;
            prf_wait_since_reg <= prf_wait_since_next;
        end
    end

endmodule

### hw/rtl/fsbc_remain.sv
// Remaining boost time and minute saturation check.
`timescale 1ns / 1ps

module fsbc_remain
(
    input  logic                              boost_on,
    input  logic [fsbc_pkg::TIME_W-1:0]       boost_end,
    input  logic [fsbc_pkg::TIME_W-1:0]       now_ms,
    output logic                              rem_ok,
    output logic                              rem_sat,
    output logic [fsbc_pkg::REM_W-1:0]        rem
);

    logic [fsbc_pkg::TIME_W-1:0] diff;

    assign diff    = boost_end - now_ms;
    assign rem_ok  = boost_on && (now_ms < boost_end);
    assign rem_sat = diff >= fsbc_pkg::SAT_REM;
    // Only meaningful when not saturated, where it fits in REM_W bits
    assign rem     = diff[fsbc_pkg::REM_W-1:0];

endmodule

### hw/rtl/fsbc_minutes.sv
// Rounded-up minutes from remaining milliseconds by reciprocal multiply.
`timescale 1ns / 1ps

module fsbc_minutes
(
    input  logic                              rem_ok,
    input  logic                              rem_sat,
    input  logic [fsbc_pkg::REM_W-1:0]        rem,
    output logic [fsbc_pkg::MIN_W-1:0]        minutes
);

    logic [fsbc_pkg::REM_W-1:0]  rounded;
    logic [fsbc_pkg::PROD_W-1:0] prod;

    assign rounded = rem + fsbc_pkg::ROUND_UP_MS;
    assign prod    = fsbc_pkg::PROD_W'(rounded) * fsbc_pkg::PROD_W'(fsbc_pkg::RECIP);

    always_comb
    begin
        if (!rem_ok)
        begin
            minutes = '0;
        end
        else if (rem_sat)
        begin
            minutes = fsbc_pkg::MINUTES_CAP;
        end
        else
        begin
            minutes = prod[fsbc_pkg::RECIP_SHIFT +: fsbc_pkg::MIN_W];
        end
    end

endmodule

### hw/rtl/fan_speed_boost_controller_core.sv
// Path: an accepted transaction goes from the input register through s1 and s2 to the output register.
// Throughput: one transaction per cycle when not stalled; state updates as an item leaves the input register.
// Pipeline: input register, state update, remaining-time subtract, minute multiply.
// Reset: asynchronous active-low; state, configuration and all valid flags return to defaults.
// Configuration writes are registered whenever cfg_valid is high (cfg_ready is always high).
`timescale 1ns / 1ps

module fan_speed_boost_controller_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fsbc_pkg::KIND_W-1:0]         kind,
    input  logic [fsbc_pkg::VALUE_W-1:0]        value,
    input  logic [fsbc_pkg::TIME_W-1:0]         now_ms,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fsbc_pkg::SPEED_W-1:0]        fan_speed,
    output logic                                boost_on,
    output logic [fsbc_pkg::MIN_W-1:0]          boost_minutes,
    output logic                                timer_refresh,
    output logic [fsbc_pkg::PROFILE_W-1:0]      profile,
    output logic                                send_speed_valid,
    output logic [fsbc_pkg::SPEED_W-1:0]        send_speed_level,
    output logic                                send_profile_valid,
    output logic [fsbc_pkg::PROFILE_W-1:0]      send_profile_code,
    output logic                                link_lost,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsbc_pkg::TIME_W-1:0]         cfg_data
);

    fsbc_pkg::cfg_t    cfg;
    fsbc_pkg::status_t step_status;
    logic [fsbc_pkg::TIME_W-1:0] step_boost_end;

    logic                            in_v_reg;
    logic [fsbc_pkg::KIND_W-1:0]     kind_reg;
    logic [fsbc_pkg::VALUE_W-1:0]    value_reg;
    logic [fsbc_pkg::TIME_W-1:0]     now_reg;

    logic                            s1_v_reg;
    fsbc_pkg::status_t               s1_status_reg;
    logic [fsbc_pkg::TIME_W-1:0]     s1_end_reg;
    logic [fsbc_pkg::TIME_W-1:0]     s1_now_reg;

    logic                            s2_v_reg;
    fsbc_pkg::status_t               s2_status_reg;
    logic                            s2_ok_reg;
    logic                            s2_sat_reg;
    logic [fsbc_pkg::REM_W-1:0]      s2_rem_reg;

    logic                            out_v_reg;
    fsbc_pkg::status_t               out_status_reg;
    logic [fsbc_pkg::MIN_W-1:0]      out_min_reg;

    logic                            rem_ok;
    logic                            rem_sat;
    logic [fsbc_pkg::REM_W-1:0]      rem;
    logic [fsbc_pkg::MIN_W-1:0]      minutes;

    logic ready_out;
    logic ready_s2;
    logic ready_s1;
    logic ready_in;
    logic fire;

    // Each stage loads when empty or when its contents move on
    assign ready_out = !out_v_reg || !out_stall;
    assign ready_s2  = !s2_v_reg || ready_out;
    assign ready_s1  = !s1_v_reg || ready_s2;
    assign ready_in  = !in_v_reg || ready_s1;
    assign fire      = in_v_reg && ready_s1;
    assign in_stall  = !ready_in;
    assign cfg_ready = 1'b1;

    fsbc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsbc_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (kind_reg),
        .value     (value_reg),
        .now_ms    (now_reg),
        .cfg       (cfg),
        .status    (step_status),
        .boost_end (step_boost_end)
    );

    fsbc_remain u_remain
    (
        .boost_on  (s1_status_reg.boost_on),
        .boost_end (s1_end_reg),
        .now_ms    (s1_now_reg),
        .rem_ok    (rem_ok),
        .rem_sat   (rem_sat),
        .rem       (rem)
    );

    fsbc_minutes u_minutes
    (
        .rem_ok  (s2_ok_reg),
        .rem_sat (s2_sat_reg),
        .rem     (s2_rem_reg),
        .minutes (minutes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ready_in)
            begin
                in_v_reg <= in_valid;
            end
            if (ready_s1)
            begin
                s1_v_reg <= in_v_reg;
            end
            if (ready_s2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (ready_out)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && in_valid)
        begin
            kind_reg  <= kind;
            value_reg <= value;
            now_reg   <= now_ms;
        end
        if (fire)
        begin
            s1_status_reg <= step_status;
            s1_end_reg    <= step_boost_end;
            s1_now_reg    <= now_reg;
        end
        if (ready_s2 && s1_v_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_ok_reg     <= rem_ok;
            s2_sat_reg    <= rem_sat;
            s2_rem_reg    <= rem;
        end
        if (ready_out && s2_v_reg)
        begin
            out_status_reg <= s2_status_reg;
            out_min_reg    <= minutes;
        end
    end

    assign out_valid          = out_v_reg;
    assign fan_speed          = out_status_reg.fan_speed;
    assign boost_on           = out_status_reg.boost_on;
    assign boost_minutes      = out_min_reg;
    assign timer_refresh      = out_status_reg.timer_refresh;
    assign profile            = out_status_reg.profile;
    assign send_speed_valid   = out_status_reg.send_speed_valid;
    assign send_speed_level   = out_status_reg.send_speed_level;
    assign send_profile_valid = out_status_reg.send_profile_valid;
    assign send_profile_code  = out_status_reg.send_profile_code;
    assign link_lost          = out_status_reg.link_lost;

    a_minutes_need_boost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (boost_minutes == '0 || boost_on))
        else $error("boost minutes reported without a running boost");

    a_minutes_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (boost_minutes <= fsbc_pkg::MINUTES_CAP))
        else $error("boost minutes above cap");

    a_refresh_needs_boost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timer_refresh |-> boost_on)
        else $error("timer refresh without a running boost");

    a_idle_commands_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((send_speed_valid || send_speed_level == '0)
                    && (send_profile_valid || send_profile_code == '0)))
        else $error("command payload nonzero without its valid bit");

endmodule

### dv/testbench.sv
// Self-checking testbench for the fan speed and boost controller core.
`timescale 1ns / 1ps

module testbench;

    import fsbc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int PRINT_CAP = 200;
    localparam int PHASES = 6;
    localparam int EVENTS_PER_PHASE = 190;

    // Field order matches the concatenation of the result ports below
    typedef struct packed {
        logic [SPEED_W-1:0]   fan_speed;
        logic                 boost_on;
        logic [MIN_W-1:0]     boost_minutes;
        logic                 timer_refresh;
        logic [PROFILE_W-1:0] profile;
        logic                 send_speed_valid;
        logic [SPEED_W-1:0]   send_speed_level;
        logic                 send_profile_valid;
        logic [PROFILE_W-1:0] send_profile_code;
        logic                 link_lost;
    } fan_status_t;

    class fan_ctrl_scoreboard;
        logic                 remote_mode;
        logic [TIME_W-1:0]    boost_len;
        logic [DEB_W-1:0]     debounce;
        logic [TIME_W-1:0]    link_timeout;

        logic [SPEED_W-1:0]   speed_now;
        logic [SPEED_W-1:0]   speed_saved;
        logic [PROFILE_W-1:0] profile_now;
        logic                 boosting;
        logic [TIME_W-1:0]    boost_end;
        logic [TIME_W-1:0]    last_refresh;
        logic                 feedback_seen;
        logic [TIME_W-1:0]    last_feedback;
        logic                 speed_wait;
        logic [SPEED_W-1:0]   speed_wait_level;
        logic [TIME_W-1:0]    speed_wait_since;
        logic                 profile_wait;
        logic [PROFILE_W-1:0] profile_wait_code;
        logic [TIME_W-1:0]    profile_wait_since;

        fan_status_t expected_q[$];
        fan_status_t cur;
        int errors;
        int checked;
        int boosts_started;
        int boosts_expired;

        function new();
            remote_mode = 1'b0;
            boost_len = BOOST_LEN_RST;
            debounce = DEBOUNCE_RST;
            link_timeout = LINK_TO_RST;
            speed_now = SPEED_RST;
            speed_saved = SPEED_RST;
            profile_now = PROFILE_RST;
            boosting = 1'b0;
            boost_end = '0;
            last_refresh = '0;
            feedback_seen = 1'b0;
            last_feedback = '0;
            speed_wait = 1'b0;
            speed_wait_level = SPEED_RST;
            speed_wait_since = '0;
            profile_wait = 1'b0;
            profile_wait_code = PROFILE_RST;
            profile_wait_since = '0;
            errors = 0;
            checked = 0;
            boosts_started = 0;
            boosts_expired = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [TIME_W-1:0] data);
            case (idx)
                CFG_REMOTE_MODE:  remote_mode = data[0];
                CFG_BOOST_LENGTH: boost_len = data;
                CFG_DEBOUNCE:     debounce = data[DEB_W-1:0];
                CFG_LINK_TIMEOUT: link_timeout = data;
                default: ;
            endcase
        endfunction

        function void issue_speed(logic [SPEED_W-1:0] lvl);
            cur.send_speed_valid = 1'b1;
            cur.send_speed_level = lvl;
        endfunction

        function void issue_profile(logic [PROFILE_W-1:0] code);
            cur.send_profile_valid = 1'b1;
            cur.send_profile_code = code;
        endfunction

        function void end_boost();
            boosting = 1'b0;
            boost_end = '0;
            speed_now = speed_saved;
            issue_speed(speed_now);
        endfunction

        function void manual_speed(logic [TIME_W-1:0] now, bit up);
            if (boosting)
            begin
                end_boost();
                return;
            end
            if (up)
            begin
                if (speed_now >= TOP_SPEED)
                    return;
                speed_now = speed_now + 1'b1;
            end
            else
            begin
                if (speed_now == '0)
                    return;
                speed_now = speed_now - 1'b1;
            end
            speed_saved = speed_now;
            if (remote_mode)
            begin
                speed_wait = 1'b1;
                speed_wait_level = speed_now;
                speed_wait_since = now;
            end
            else
                issue_speed(speed_now);
        endfunction

        // Advance the controller by one event and queue the status it must report
        function void note_event(logic [KIND_W-1:0] code, logic [VALUE_W-1:0] arg,
                                 logic [TIME_W-1:0] now);
            logic [VALUE_W-1:0] val;
            logic [TIME_W-1:0]  age;
            logic [63:0]        mins;

            cur = '0;
            val = arg;
            case (code)
                KIND_TICK:
                begin
                    if (boosting)
                    begin
                        age = now - last_refresh;
                        if (now >= boost_end)
                        begin
                            end_boost();
                            boosts_expired++;
                        end
                        else if (age >= MS_PER_MIN)
                        begin
                            last_refresh = now;
                            cur.timer_refresh = 1'b1;
                        end
                    end
                    if (remote_mode)
                    begin
                        age = now - speed_wait_since;
                        if (speed_wait && age >= {16'd0, debounce})
                        begin
                            issue_speed(speed_wait_level);
                            speed_wait = 1'b0;
                        end
                        age = now - profile_wait_since;
                        if (profile_wait && age >= {16'd0, debounce})
                        begin
                            issue_profile(profile_wait_code);
                            profile_wait = 1'b0;
                        end
                    end
                end
                KIND_UP:   manual_speed(now, 1'b1);
                KIND_DOWN: manual_speed(now, 1'b0);
                KIND_BOOST:
                begin
                    if (boosting)
                        boost_end = boost_end + boost_len;
                    else
                    begin
                        speed_saved = speed_now;
                        speed_now = TOP_SPEED;
                        boosting = 1'b1;
                        boost_end = now + boost_len;
                        last_refresh = now;
                        issue_speed(TOP_SPEED);
                        boosts_started++;
                    end
                end
                KIND_SET_PROFILE:
                begin
                    if (boosting)
                        end_boost();
                    if (val > TOP_PROFILE)
                        val = '0;
                    profile_now = val[PROFILE_W-1:0];
                    if (remote_mode)
                    begin
                        profile_wait = 1'b1;
                        profile_wait_code = val[PROFILE_W-1:0];
                        profile_wait_since = now;
                    end
                    else
                        issue_profile(val[PROFILE_W-1:0]);
                end
                KIND_SPEED_FB:
                begin
                    feedback_seen = 1'b1;
                    last_feedback = now;
                    if (val > TOP_SPEED)
                        val = TOP_SPEED;
                    // during boost only the link time moves
                    if (!boosting && val[SPEED_W-1:0] != speed_now)
                    begin
                        speed_now = val[SPEED_W-1:0];
                        speed_saved = val[SPEED_W-1:0];
                        if (remote_mode && speed_wait && val[SPEED_W-1:0] == speed_wait_level)
                            speed_wait = 1'b0;
                    end
                end
                KIND_PROFILE_FB:
                begin
                    feedback_seen = 1'b1;
                    last_feedback = now;
                    if (val > TOP_PROFILE)
                        val = '0;
                    if (val[PROFILE_W-1:0] != profile_now)
                    begin
                        profile_now = val[PROFILE_W-1:0];
                        if (remote_mode && profile_wait &&
                            val[PROFILE_W-1:0] == profile_wait_code)
                            profile_wait = 1'b0;
                    end
                end
                default: ;
            endcase

            if (boosting && now < boost_end)
            begin
                mins = ({32'd0, boost_end - now} + {32'd0, MS_PER_MIN} - 64'd1)
                       / {32'd0, MS_PER_MIN};
                cur.boost_minutes = (mins > MINUTES_CAP) ? MINUTES_CAP : mins[MIN_W-1:0];
            end

            age = now - last_feedback;
            cur.link_lost = !feedback_seen || (age > link_timeout);
            cur.fan_speed = speed_now;
            cur.boost_on = boosting;
            cur.profile = profile_now;
            expected_q.push_back(cur);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= PRINT_CAP)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_status(fan_status_t got);
            fan_status_t want;

            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_CAP)
                    $error("result transaction arrived with nothing outstanding");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("fan_speed", want.fan_speed, got.fan_speed);
            compare_field("boost_on", want.boost_on, got.boost_on);
            compare_field("boost_minutes", want.boost_minutes, got.boost_minutes);
            compare_field("timer_refresh", want.timer_refresh, got.timer_refresh);
            compare_field("profile", want.profile, got.profile);
            compare_field("send_speed_valid", want.send_speed_valid, got.send_speed_valid);
            compare_field("send_speed_level", want.send_speed_level, got.send_speed_level);
            compare_field("send_profile_valid", want.send_profile_valid,
                          got.send_profile_valid);
            compare_field("send_profile_code", want.send_profile_code, got.send_profile_code);
            compare_field("link_lost", want.link_lost, got.link_lost);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [KIND_W-1:0]      kind = KIND_TICK;
    logic [VALUE_W-1:0]     value = '0;
    logic [TIME_W-1:0]      now_ms = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SPEED_W-1:0]     fan_speed;
    logic                   boost_on;
    logic [MIN_W-1:0]       boost_minutes;
    logic                   timer_refresh;
    logic [PROFILE_W-1:0]   profile;
    logic                   send_speed_valid;
    logic [SPEED_W-1:0]     send_speed_level;
    logic                   send_profile_valid;
    logic [PROFILE_W-1:0]   send_profile_code;
    logic                   link_lost;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_REMOTE_MODE;
    logic [TIME_W-1:0]      cfg_data = '0;

    fan_status_t            observed;
    fan_ctrl_scoreboard     sb;
    logic [TIME_W-1:0]      clock_ms = '0;
    int                     events_sent = 0;
    int                     setups = 0;
    bit                     gaps_on = 1'b1;
    logic                   hold_rx = 1'b0;
    int                     stall_left = 0;
    int                     run_left = 0;

    fan_speed_boost_controller_core i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .value              (value),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .fan_speed          (fan_speed),
        .boost_on           (boost_on),
        .boost_minutes      (boost_minutes),
        .timer_refresh      (timer_refresh),
        .profile            (profile),
        .send_speed_valid   (send_speed_valid),
        .send_speed_level   (send_speed_level),
        .send_profile_valid (send_profile_valid),
        .send_profile_code  (send_profile_code),
        .link_lost          (link_lost),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    assign observed = {fan_speed, boost_on, boost_minutes, timer_refresh, profile,
                       send_speed_valid, send_speed_level, send_profile_valid,
                       send_profile_code, link_lost};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_run();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 6);
        if (r < 92)
            return $urandom_range(8, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic logic [TIME_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 1000);
        if (r < 92)
            return $urandom_range(1000, 70000);
        return $urandom();
    endfunction

    function automatic logic [VALUE_W-1:0] rand_byte();
        return VALUE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [VALUE_W-1:0] fb_speed_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return {6'd0, sb.speed_wait_level};
        if (r < 80)
            return VALUE_W'($urandom_range(0, 3));
        return rand_byte();
    endfunction

    function automatic logic [VALUE_W-1:0] fb_profile_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return {6'd0, sb.profile_wait_code};
        if (r < 80)
            return VALUE_W'($urandom_range(0, 2));
        return rand_byte();
    endfunction

    // Receive side: check every accepted result, then pick the next stall level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status(observed);
        if (stall_left == 0 && run_left == 0)
        begin
            stall_left = pick_pause();
            run_left = pick_run();
        end
        if (hold_rx)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            run_left--;
        end
    end

    // Hold the result side off for a long stretch so the input backs up
    initial
    begin
        while (events_sent < 500)
            @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Called at a rising edge; returns at the rising edge that ends the gap
    task automatic send_event(input logic [KIND_W-1:0] code, input logic [VALUE_W-1:0] arg,
                              input logic [TIME_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        kind <= code;
        value <= arg;
        now_ms <= t;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(code, arg, t);
        events_sent++;
        gap = gaps_on ? pick_pause() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic emit(input logic [KIND_W-1:0] code, input logic [VALUE_W-1:0] arg,
                        input logic [TIME_W-1:0] step);
        clock_ms = clock_ms + step;
        send_event(code, arg, clock_ms);
    endtask

    task automatic emit_at(input logic [KIND_W-1:0] code, input logic [VALUE_W-1:0] arg,
                           input logic [TIME_W-1:0] t);
        clock_ms = t;
        send_event(code, arg, clock_ms);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_setup(input logic remote, input logic [TIME_W-1:0] boost_len,
                               input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] link);
        cfg_index_t        order [4];
        logic [TIME_W-1:0] data [4];
        int                n;

        order = '{CFG_REMOTE_MODE, CFG_BOOST_LENGTH, CFG_DEBOUNCE, CFG_LINK_TIMEOUT};
        data = '{{31'd0, remote}, boost_len, {16'd0, deb}, link};
        wait_drained();
        for (n = 0; n < 4; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[n];
            cfg_data <= data[n];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(order[n], data[n]);
        end
        cfg_valid <= 1'b0;
        setups++;
    endtask

    task automatic manual_burst();
        int presses;
        int waits;
        int n;
        presses = $urandom_range(1, 4);
        for (n = 0; n < presses; n++)
            emit($urandom_range(0, 1) ? KIND_UP : KIND_DOWN, rand_byte(),
                 $urandom_range(0, 400));
        if ($urandom_range(0, 1))
            emit(KIND_SPEED_FB, fb_speed_value(), $urandom_range(0, 300));
        waits = $urandom_range(1, 4);
        for (n = 0; n < waits; n++)
            emit(KIND_TICK, rand_byte(), $urandom_range(0, 2 * sb.debounce + 20));
    endtask

    task automatic profile_burst();
        int waits;
        int n;
        emit(KIND_SET_PROFILE,
             ($urandom_range(0, 6) == 0) ? rand_byte() : VALUE_W'($urandom_range(0, 2)),
             $urandom_range(0, 400));
        if ($urandom_range(0, 1))
        begin
            emit(KIND_PROFILE_FB, VALUE_W'($urandom_range(0, 2)), $urandom_range(0, 300));
            emit(KIND_PROFILE_FB, fb_profile_value(), $urandom_range(0, 300));
        end
        waits = $urandom_range(1, 3);
        for (n = 0; n < waits; n++)
            emit(KIND_TICK, rand_byte(), $urandom_range(0, 2 * sb.debounce + 20));
    endtask

    task automatic boost_run();
        int ticks;
        int n;
        ticks = $urandom_range(3, 25);
        emit(KIND_BOOST, rand_byte(), pick_step());
        if ($urandom_range(0, 9) < 3)
            emit(KIND_BOOST, rand_byte(), $urandom_range(0, 30000));
        for (n = 0; n < ticks && sb.boosting; n++)
        begin
            case ($urandom_range(0, 29))
                0: emit(KIND_DOWN, rand_byte(), $urandom_range(0, 5000));
                1: emit(KIND_UP, rand_byte(), $urandom_range(0, 5000));
                2: emit(KIND_SET_PROFILE, rand_byte(), $urandom_range(0, 5000));
                3: emit(KIND_SPEED_FB, fb_speed_value(), $urandom_range(0, 5000));
                4: emit(KIND_BOOST, rand_byte(), $urandom_range(0, 5000));
                default: emit(KIND_TICK, rand_byte(), $urandom_range(1000, 90000));
            endcase
        end
    endtask

    task automatic feedback_once();
        if ($urandom_range(0, 1))
            emit(KIND_SPEED_FB, fb_speed_value(), pick_step());
        else
            emit(KIND_PROFILE_FB, fb_profile_value(), pick_step());
    endtask

    task automatic noise_event();
        emit_at(KIND_W'($urandom_range(0, 7)), rand_byte(), $urandom());
    endtask

    initial
    begin
        int phase;
        int target;
        int unsigned r;

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every kind, saturation at both ends, out-of-range values
        emit_at(KIND_TICK, 8'd0, 32'd0);
        emit(KIND_UP, 8'hFF, 32'd10);
        emit(KIND_UP, 8'd0, 32'd10);
        emit(KIND_DOWN, 8'd0, 32'd10);
        emit(KIND_DOWN, 8'd0, 32'd10);
        emit(KIND_DOWN, 8'd0, 32'd10);
        emit(KIND_DOWN, 8'd0, 32'd10);
        emit(KIND_SET_PROFILE, 8'hFF, 32'd10);
        emit(KIND_SET_PROFILE, 8'd2, 32'd10);
        emit(KIND_SPEED_FB, 8'hFF, 32'd10);
        emit(KIND_PROFILE_FB, 8'd3, 32'd10);
        emit(KIND_UNUSED, 8'hAA, 32'd10);
        emit(KIND_BOOST, 8'd0, 32'd10);
        emit(KIND_BOOST, 8'd0, 32'd10);
        emit(KIND_SPEED_FB, 8'd1, 32'd10);
        emit(KIND_TICK, 8'd0, MS_PER_MIN);
        emit(KIND_TICK, 8'd0, MS_PER_MIN - 1);
        emit(KIND_DOWN, 8'd0, 32'd10);
        // boost end wraps past zero and compares below now, so the next tick ends it
        emit_at(KIND_BOOST, 8'd0, 32'hFFFF_FFF0);
        emit(KIND_TICK, 8'd0, 32'd5);

        // Zero boost, zero debounce, zero link timeout: boost end and debounced
        // command land on one tick
        write_setup(1'b1, 32'd0, 16'd0, 32'd0);
        emit((sb.speed_now == '0) ? KIND_UP : KIND_DOWN, 8'd0, 32'd100);
        emit(KIND_SPEED_FB, {6'd0, sb.speed_wait_level ^ 2'b01}, 32'd0);
        emit(KIND_BOOST, 8'd0, 32'd0);
        emit(KIND_TICK, 8'd0, 32'd0);
        emit(KIND_TICK, 8'd0, 32'd1);
        emit(KIND_SET_PROFILE, 8'd1, 32'd5);

        // A pending command is held while remote mode is off
        write_setup(1'b0, BOOST_LEN_RST, 16'hFFFF, 32'hFFFF_FFFF);
        emit(KIND_TICK, 8'd0, 32'd100000);
        write_setup(1'b1, BOOST_LEN_RST, 16'hFFFF, 32'hFFFF_FFFF);
        emit(KIND_TICK, 8'd0, 32'd10);
        emit(KIND_SET_PROFILE, 8'd2, 32'd10);
        emit(KIND_PROFILE_FB, 8'd1, 32'd10);
        emit(KIND_PROFILE_FB, 8'd2, 32'd10);
        emit(KIND_TICK, 8'd0, 32'd70000);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_setup(1'b1, $urandom_range(60000, 400000), $urandom_range(1, 3000),
                               $urandom_range(1000, 30000));
                1: write_setup(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
                2: write_setup(1'b1, 32'd1, 16'd0, 32'd0);
                3: write_setup(1'b1, $urandom(), DEB_W'($urandom()), $urandom());
                4: write_setup(1'b0, $urandom_range(30000, 200000), DEB_W'($urandom()),
                               $urandom_range(0, 5000));
                default: write_setup(1'b1, BOOST_LEN_RST, 16'hFFFF, LINK_TO_RST);
            endcase
            target = events_sent + EVENTS_PER_PHASE;
            while (events_sent < target)
            begin
                gaps_on = ($urandom_range(0, 4) != 0);
                r = $urandom_range(0, 99);
                if (r < 25)
                    manual_burst();
                else if (r < 40)
                    profile_burst();
                else if (r < 65)
                    boost_run();
                else if (r < 82)
                    feedback_once();
                else
                    noise_event();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d events over %0d register setups.",
                 sb.checked, events_sent, setups);
        $display("Boosts started %0d, boosts timed out %0d, with one long result hold-off.",
                 sb.boosts_started, sb.boosts_expired);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### fan_speed_boost_controller_core.f
hw/rtl/fsbc_pkg.sv
hw/rtl/fsbc_cfg.sv
hw/rtl/fsbc_step.sv
hw/rtl/fsbc_remain.sv
hw/rtl/fsbc_minutes.sv
hw/rtl/fan_speed_boost_controller_core.sv
dv/testbench.sv
